/* rtl/tbfl_pkg.sv */
// ----------------------------------------------------------------------------
// tbfl_pkg
// Shared types and constants of the two-tier block free list: payload
// structs, the command passed from the front end to the back end, and codes.
// ----------------------------------------------------------------------------
package tbfl_pkg;

  localparam int POOL_BLOCKS  = 1024;
  localparam int REQUESTERS   = 4;
  localparam int QUEUE_DEPTH  = 2;

  localparam int LIMIT_W      = 11;
  localparam int IDX_W        = 10;
  localparam int REQ_W        = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd256;

  // Values of the func field.
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Operation codes after classification.
  localparam logic [1:0] OP_NOP   = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  typedef struct packed {
    logic             func;
    logic [REQ_W-1:0] requester;
    logic [IDX_W-1:0] block_index;
    logic             block_present;
  } tbfl_req_t;

  typedef struct packed {
    logic             granted;
    logic [IDX_W-1:0] granted_index;
    logic             out_of_memory;
    logic             freed_to_global;
  } tbfl_rsp_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [REQ_W-1:0] requester;
    logic [IDX_W-1:0] block_index;
  } tbfl_cmd_t;

endpackage

/* rtl/two_tier_block_free_list.sv */
// ----------------------------------------------------------------------------
// two_tier_block_free_list
// Fixed-size block allocator with a shared global free list and one cache
// list per requester, all chained through a single link memory.
// ----------------------------------------------------------------------------
//
//   Port group   Direction  Handshake              Payload
//   req          in         req_valid / req_ready  tbfl_req_t
//   rsp          out        rsp_valid / rsp_ready  tbfl_rsp_t
//   cfg          in         cfg_we                 cfg_wdata (cache limit)
//
// A request passes through the combinational front end into the registered
// command queue. In the back end a free or a no-op is handled in idle, and an
// allocate from a filled cache waits on the registered read of the link memory.
// A refill moves blocks one by one, since each move reads a link and then writes one.
// After reset a clearing pass over all POOL_BLOCKS entries rebuilds the link chain and
// holds req_ready low. A stalled response holds the back end; the queue absorbs requests.
module two_tier_block_free_list #(
  parameter int POOL_BLOCKS = tbfl_pkg::POOL_BLOCKS,
  parameter int REQUESTERS  = tbfl_pkg::REQUESTERS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [tbfl_pkg::LIMIT_W-1:0] cfg_wdata,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  tbfl_pkg::tbfl_req_t          req,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output tbfl_pkg::tbfl_rsp_t          rsp
);

  logic                clearing;
  logic                push_valid;
  logic                push_ready;
  tbfl_pkg::tbfl_cmd_t push_cmd;
  logic                cmd_valid;
  logic                cmd_ready;
  tbfl_pkg::tbfl_cmd_t cmd;

  tbfl_front #(
    .POOL_BLOCKS(POOL_BLOCKS),
    .REQUESTERS (REQUESTERS)
  ) u_front (
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .clearing  (clearing),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd)
  );

  tbfl_queue #(
    .DEPTH(tbfl_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd),
    .pop_valid (cmd_valid),
    .pop_ready (cmd_ready),
    .pop_cmd   (cmd)
  );

  tbfl_back #(
    .POOL_BLOCKS(POOL_BLOCKS),
    .REQUESTERS (REQUESTERS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .clearing (clearing)
  );

endmodule

/* rtl/tbfl_ram.sv */
// ----------------------------------------------------------------------------
// tbfl_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module tbfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/tbfl_front.sv */
// ----------------------------------------------------------------------------
// tbfl_front
// Request front end: accepts request transactions and classifies each one
// into an allocate, a free or a no-op before it enters the command queue.
// ----------------------------------------------------------------------------
module tbfl_front #(
  parameter int POOL_BLOCKS = tbfl_pkg::POOL_BLOCKS,
  parameter int REQUESTERS  = tbfl_pkg::REQUESTERS
) (
  input  logic                req_valid,
  output logic                req_ready,
  input  tbfl_pkg::tbfl_req_t req,
  input  logic                clearing,
  output logic                push_valid,
  input  logic                push_ready,
  output tbfl_pkg::tbfl_cmd_t push_cmd
);

  logic req_known;
  logic blk_in_pool;

  assign req_known   = 32'(req.requester) < REQUESTERS;
  assign blk_in_pool = 32'(req.block_index) < POOL_BLOCKS;

  // No request is taken while the link memory is being rebuilt after reset.
  assign req_ready  = push_ready && !clearing;
  assign push_valid = req_valid && !clearing;

  always_comb begin
    push_cmd.requester   = req.requester;
    push_cmd.block_index = req.block_index;
    if (!req_known) begin
      push_cmd.op = tbfl_pkg::OP_NOP;
    end else if (req.func == tbfl_pkg::FUNC_ALLOC) begin
      push_cmd.op = tbfl_pkg::OP_ALLOC;
    end else if (req.block_present && blk_in_pool) begin
      push_cmd.op = tbfl_pkg::OP_FREE;
    end else begin
      push_cmd.op = tbfl_pkg::OP_NOP;
    end
  end

endmodule

/* rtl/tbfl_queue.sv */
// ----------------------------------------------------------------------------
// tbfl_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tbfl_queue #(
  parameter int DEPTH = tbfl_pkg::QUEUE_DEPTH,
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  tbfl_pkg::tbfl_cmd_t push_cmd,
  output logic                pop_valid,
  input  logic                pop_ready,
  output tbfl_pkg::tbfl_cmd_t pop_cmd
);

  tbfl_pkg::tbfl_cmd_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = count != CW'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* rtl/tbfl_back.sv */
// ----------------------------------------------------------------------------
// tbfl_back
// Back end: owns the link memory, the global head and the per-requester
// cache lists, carries out allocate, free and refill, and holds the
// response register.
// ----------------------------------------------------------------------------
module tbfl_back #(
  parameter int POOL_BLOCKS = tbfl_pkg::POOL_BLOCKS,
  parameter int REQUESTERS  = tbfl_pkg::REQUESTERS,
  localparam int BW         = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1,
  localparam int LW         = $clog2(POOL_BLOCKS + 1),
  localparam int RW         = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tbfl_pkg::LIMIT_W-1:0]       cfg_wdata,
  input  logic                               cmd_valid,
  output logic                               cmd_ready,
  input  tbfl_pkg::tbfl_cmd_t                cmd,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output tbfl_pkg::tbfl_rsp_t                rsp,
  output logic                               clearing
);

  localparam logic [LW-1:0] NIL = LW'(POOL_BLOCKS);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_REF_CHK = 3'd2;
  localparam logic [2:0] S_REF_WB  = 3'd3;
  localparam logic [2:0] S_POP_WB  = 3'd4;

  logic [2:0]                      state;
  logic [BW-1:0]                   clr_addr;
  logic [RW-1:0]                   cur_req;
  logic [LW-1:0]                   global_head;
  logic [LW-1:0]                   cache_head [REQUESTERS];
  logic [tbfl_pkg::LIMIT_W-1:0]    cache_fill [REQUESTERS];
  logic [tbfl_pkg::LIMIT_W-1:0]    fill_cap;

  logic [RW-1:0]                   ridx;
  logic [LW-1:0]                   head_sel;
  logic [tbfl_pkg::LIMIT_W-1:0]    fill_sel;
  logic [tbfl_pkg::LIMIT_W-1:0]    lim;
  logic                            head_ok;
  logic                            glob_ok;
  logic                            has_room;
  logic                            can_emit;
  logic                            emit;
  tbfl_pkg::tbfl_rsp_t             rsp_next;

  logic                            ram_we;
  logic [BW-1:0]                   ram_waddr;
  logic [LW-1:0]                   ram_wdata;
  logic                            ram_re;
  logic [BW-1:0]                   ram_raddr;
  logic [LW-1:0]                   ram_rdata;

  tbfl_ram #(
    .WIDTH(LW),
    .DEPTH(POOL_BLOCKS)
  ) u_link_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (ram_re),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  // One cache is looked at per cycle: the queue head's in idle, else the
  // one whose allocate is in progress.
  assign ridx     = (state == S_IDLE) ? RW'(cmd.requester) : cur_req;
  assign head_sel = cache_head[ridx];
  assign fill_sel = cache_fill[ridx];
  assign lim      = (fill_cap == '0) ? tbfl_pkg::LIMIT_W'(1) : fill_cap;
  assign head_ok  = head_sel < NIL;
  assign glob_ok  = global_head < NIL;
  assign has_room = fill_sel < lim;
  assign can_emit = !rsp_valid || rsp_ready;
  assign clearing = state == S_CLEAR;

  always_comb begin
    cmd_ready = 1'b0;
    if (state == S_IDLE && cmd_valid) begin
      unique case (cmd.op)
        tbfl_pkg::OP_ALLOC: cmd_ready = 1'b1;
        default:            cmd_ready = can_emit;
      endcase
    end
  end

  always_comb begin
    emit     = 1'b0;
    rsp_next = '0;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid && cmd.op != tbfl_pkg::OP_ALLOC && can_emit) begin
          emit                     = 1'b1;
          rsp_next.freed_to_global = (cmd.op == tbfl_pkg::OP_FREE) && !has_room;
        end
      end
      S_REF_CHK: begin
        if (!(glob_ok && has_room) && !(fill_sel != '0 && head_ok) &&
            can_emit) begin
          emit                   = 1'b1;
          rsp_next.out_of_memory = 1'b1;
        end
      end
      S_POP_WB: begin
        if (can_emit) begin
          emit                   = 1'b1;
          rsp_next.granted       = 1'b1;
          rsp_next.granted_index = tbfl_pkg::IDX_W'(head_sel);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = LW'(clr_addr) + LW'(1);
    ram_re    = 1'b0;
    ram_raddr = BW'(head_sel);
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        if (cmd_valid && cmd.op == tbfl_pkg::OP_FREE && can_emit) begin
          ram_we    = 1'b1;
          ram_waddr = BW'(cmd.block_index);
          ram_wdata = has_room ? head_sel : global_head;
        end else if (cmd_valid && cmd.op == tbfl_pkg::OP_ALLOC &&
                     fill_sel != '0 && head_ok) begin
          ram_re = 1'b1;
        end
      end
      S_REF_CHK: begin
        if (glob_ok && has_room) begin
          ram_re    = 1'b1;
          ram_raddr = BW'(global_head);
        end else if (fill_sel != '0 && head_ok) begin
          ram_re = 1'b1;
        end
      end
      S_REF_WB: begin
        // The block leaving the global list links to the old cache head.
        ram_we    = 1'b1;
        ram_waddr = BW'(global_head);
        ram_wdata = head_sel;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      cur_req     <= '0;
      global_head <= '0;
      fill_cap    <= tbfl_pkg::LIMIT_RESET;
      rsp_valid   <= 1'b0;
      rsp         <= '0;
      for (int i = 0; i < REQUESTERS; i++) begin
        cache_head[i] <= NIL;
        cache_fill[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        fill_cap <= cfg_wdata;
      end
      if (emit) begin
        rsp_valid <= 1'b1;
        rsp       <= rsp_next;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + BW'(1);
          if (clr_addr == BW'(POOL_BLOCKS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            unique case (cmd.op)
              tbfl_pkg::OP_ALLOC: begin
                cur_req <= ridx;
                if (fill_sel != '0 && head_ok) begin
                  state <= S_POP_WB;
                end else begin
                  // An empty or broken cache is reset before the refill.
                  cache_head[ridx] <= NIL;
                  cache_fill[ridx] <= '0;
                  state            <= S_REF_CHK;
                end
              end
              tbfl_pkg::OP_FREE: begin
                if (can_emit) begin
                  if (has_room) begin
                    cache_head[ridx] <= LW'(cmd.block_index);
                    cache_fill[ridx] <= fill_sel + tbfl_pkg::LIMIT_W'(1);
                  end else begin
                    global_head <= LW'(cmd.block_index);
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_REF_CHK: begin
          if (glob_ok && has_room) begin
            state <= S_REF_WB;
          end else if (fill_sel != '0 && head_ok) begin
            state <= S_POP_WB;
          end else if (can_emit) begin
            state <= S_IDLE;
          end
        end
        S_REF_WB: begin
          cache_head[cur_req] <= global_head;
          cache_fill[cur_req] <= fill_sel + tbfl_pkg::LIMIT_W'(1);
          global_head         <= ram_rdata;
          state               <= S_REF_CHK;
        end
        S_POP_WB: begin
          if (can_emit) begin
            cache_head[cur_req] <= ram_rdata;
            cache_fill[cur_req] <= fill_sel - tbfl_pkg::LIMIT_W'(1);
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sim/two_tier_block_free_list_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_tier_block_free_list_test
// Self-checking testbench for the two-tier block free list. A behavioral
// copy of the global list, the per-requester caches and the link store
// predicts every response. Directed cases cover refill, out of memory, the
// zero and lowered cache limits, double frees and broken caches. Random
// traffic then frees the blocks that were granted, with noise mixed in,
// under a range of cache limits and handshake stall patterns.
// ----------------------------------------------------------------------------
module two_tier_block_free_list_test;

  localparam int NULL_LINK      = tbfl_pkg::POOL_BLOCKS;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 10;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      cfg_we    = 1'b0;
  logic [tbfl_pkg::LIMIT_W-1:0] cfg_wdata = '0;
  logic      req_valid = 1'b0;
  logic      req_ready;
  tbfl_pkg::tbfl_req_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  tbfl_pkg::tbfl_rsp_t rsp;

  two_tier_block_free_list DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // Predicted allocator state.
  int next_free [tbfl_pkg::POOL_BLOCKS];
  int global_top;
  int cache_top [tbfl_pkg::REQUESTERS];
  int cache_size [tbfl_pkg::REQUESTERS];
  int limit_setting;

  tbfl_pkg::tbfl_rsp_t expected_rsp [$];
  int        held_blocks [$];
  int        error_count  = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        quiet_cycles  = 0;

  function automatic void reset_pool_model();
    for (int i = 0; i < tbfl_pkg::POOL_BLOCKS; i++) next_free[i] = i + 1;
    global_top = 0;
    for (int r = 0; r < tbfl_pkg::REQUESTERS; r++) begin
      cache_top[r]  = NULL_LINK;
      cache_size[r] = 0;
    end
    limit_setting = tbfl_pkg::LIMIT_RESET;
  endfunction

  function automatic tbfl_pkg::tbfl_rsp_t predict_response(input tbfl_pkg::tbfl_req_t item);
    tbfl_pkg::tbfl_rsp_t res;
    int r;
    int lim;
    int moved;
    int blk;
    res = '0;
    r = item.requester;
    lim = (limit_setting == 0) ? 1 : limit_setting;
    if (item.func == tbfl_pkg::FUNC_ALLOC) begin
      // An empty cache, or one whose chain ended early, is refilled first.
      if (cache_size[r] == 0 || cache_top[r] >= NULL_LINK) begin
        cache_top[r] = NULL_LINK;
        moved = 0;
        while (global_top < NULL_LINK && moved < lim) begin
          blk = global_top;
          global_top = next_free[blk];
          next_free[blk] = cache_top[r];
          cache_top[r] = blk;
          moved++;
        end
        cache_size[r] = moved;
      end
      if (cache_size[r] > 0 && cache_top[r] < NULL_LINK) begin
        blk = cache_top[r];
        cache_top[r] = next_free[blk];
        cache_size[r]--;
        res.granted = 1'b1;
        res.granted_index = tbfl_pkg::IDX_W'(blk);
      end else begin
        res.out_of_memory = 1'b1;
      end
    end else if (item.block_present) begin
      blk = item.block_index;
      if (cache_size[r] < lim) begin
        next_free[blk] = cache_top[r];
        cache_top[r] = blk;
        cache_size[r]++;
      end else begin
        next_free[blk] = global_top;
        global_top = blk;
        res.freed_to_global = 1'b1;
      end
    end
    return res;
  endfunction

  // Called at a rising edge; returns at the edge where the transaction is accepted.
  task automatic send_item(input tbfl_pkg::tbfl_req_t item);
    tbfl_pkg::tbfl_rsp_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      req <= tbfl_pkg::tbfl_req_t'($urandom);
      @(posedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    want = predict_response(item);
    expected_rsp.push_back(want);
    if (want.granted) held_blocks.push_back(int'(want.granted_index));
  endtask

  task automatic send_op(input logic func, input int requester, input int blk,
                         input logic present);
    tbfl_pkg::tbfl_req_t item;
    item.func          = func;
    item.requester     = tbfl_pkg::REQ_W'(requester);
    item.block_index   = tbfl_pkg::IDX_W'(blk);
    item.block_present = present;
    send_item(item);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_cache_limit(input logic [tbfl_pkg::LIMIT_W-1:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_setting = value;
  endtask

  // Response checker and receiver stalls.
  always @(posedge clk) begin
    tbfl_pkg::tbfl_rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t: response with none expected: %p", $time, rsp);
          error_count++;
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.granted !== want.granted) begin
            $display("%0t: granted expected %0d actual %0d", $time, want.granted,
                     rsp.granted);
            error_count++;
          end
          if (rsp.granted_index !== want.granted_index) begin
            $display("%0t: granted_index expected %0d actual %0d", $time,
                     want.granted_index, rsp.granted_index);
            error_count++;
          end
          if (rsp.out_of_memory !== want.out_of_memory) begin
            $display("%0t: out_of_memory expected %0d actual %0d", $time,
                     want.out_of_memory, rsp.out_of_memory);
            error_count++;
          end
          if (rsp.freed_to_global !== want.freed_to_global) begin
            $display("%0t: freed_to_global expected %0d actual %0d", $time,
                     want.freed_to_global, rsp.freed_to_global);
            error_count++;
          end
        end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles without any transaction on either channel.
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // One requester takes the whole pool, the others then run out of memory.
  task automatic test_refill_and_out_of_memory();
    set_cache_limit(11'd1024);
    send_op(tbfl_pkg::FUNC_ALLOC, 0, 0, 1'b0);
    send_op(tbfl_pkg::FUNC_ALLOC, 1, 0, 1'b0);
    send_op(tbfl_pkg::FUNC_FREE, 1, 1023, 1'b1);
    send_op(tbfl_pkg::FUNC_ALLOC, 1, 0, 1'b0);
    send_op(tbfl_pkg::FUNC_ALLOC, 1, 0, 1'b0);
    send_op(tbfl_pkg::FUNC_FREE, 2, 0, 1'b0);
    send_op(tbfl_pkg::FUNC_FREE, 0, 1023, 1'b1);
    send_op(tbfl_pkg::FUNC_ALLOC, 3, 1023, 1'b1);
  endtask

  // Zero limit, frees above a lowered limit, double frees and the broken
  // cache that a double free leaves behind.
  task automatic test_limit_corner_cases();
    set_cache_limit(11'd0);
    send_op(tbfl_pkg::FUNC_FREE, 2, 1023, 1'b1);
    send_op(tbfl_pkg::FUNC_FREE, 2, 5, 1'b1);
    send_op(tbfl_pkg::FUNC_FREE, 0, 7, 1'b1);
    send_op(tbfl_pkg::FUNC_ALLOC, 3, 0, 1'b0);
    send_op(tbfl_pkg::FUNC_ALLOC, 2, 0, 1'b0);
    send_op(tbfl_pkg::FUNC_ALLOC, 0, 0, 1'b0);
    send_op(tbfl_pkg::FUNC_ALLOC, 0, 0, 1'b0);
    send_op(tbfl_pkg::FUNC_FREE, 1, 0, 1'b1);
    send_op(tbfl_pkg::FUNC_FREE, 1, 1023, 1'b0);
  endtask

  // Mostly allocations and frees of granted blocks, plus null frees and
  // frees of arbitrary blocks.
  task automatic test_random_traffic(input int chunk_items, input int send_pct,
                                     input int recv_pct,
                                     input logic [tbfl_pkg::LIMIT_W-1:0] limit_a,
                                     input logic [tbfl_pkg::LIMIT_W-1:0] limit_b,
                                     input logic [tbfl_pkg::LIMIT_W-1:0] limit_c);
    logic [tbfl_pkg::LIMIT_W-1:0] limits [3];
    tbfl_pkg::tbfl_req_t item;
    int roll;
    int k;
    limits[0] = limit_a;
    limits[1] = limit_b;
    limits[2] = limit_c;
    for (int c = 0; c < 3; c++) begin
      set_cache_limit(limits[c]);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int n = 0; n < chunk_items; n++) begin
        item = tbfl_pkg::tbfl_req_t'($urandom);
        roll = $urandom_range(99);
        if (roll < 45 || (held_blocks.size() == 0 && roll < 85)) begin
          item.func = tbfl_pkg::FUNC_ALLOC;
        end else if (roll < 85) begin
          k = $urandom_range(held_blocks.size() - 1);
          item.func = tbfl_pkg::FUNC_FREE;
          item.block_index = tbfl_pkg::IDX_W'(held_blocks[k]);
          item.block_present = 1'b1;
          held_blocks.delete(k);
        end else if (roll < 93) begin
          item.func = tbfl_pkg::FUNC_FREE;
          item.block_present = 1'b0;
        end else begin
          item.func = tbfl_pkg::FUNC_FREE;
          item.block_present = 1'b1;
        end
        send_item(item);
      end
    end
  endtask

  initial begin
    reset_pool_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_refill_and_out_of_memory();
    test_limit_corner_cases();
    test_random_traffic(122, 35, 75, 11'd3, 11'd1, 11'd1024);
    test_random_traffic(122, 75, 35, 11'd0, 11'd2047, 11'd17);
    test_random_traffic(122, 0, 0, 11'd256, 11'($urandom_range(2, 64)), 11'd2);
    wait_drained();
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
